// ----- hdl/life_generation_stencil_macros.svh -----
// Assertion macros shared by the stencil RTL.
// Each macro checks a property on the rising edge of aclk while reset is released.
`ifndef LIFE_GENERATION_STENCIL_MACROS_SVH
`define LIFE_GENERATION_STENCIL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LGS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants of the Game of Life generation stencil.
// ----------------------------------------------------------------------------
package lgs_pkg;

    // Configuration port widths and register reset value.
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 8'd128;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } cfg_reg_t;

    // Input commands.
    localparam logic CMD_CELL  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Result position fields.
    localparam int POS_FIELD_W = 7;

    // 3x3 window: bits [2:0] two rows up, [5:3] one row up, [8:6] newest row.
    localparam int WINDOW_W = 9;

    // Each line cell carries one bit of each of the two line stores.
    localparam int LINE_TAPS = 2;

    // Neighbor count and the B3/S23 thresholds.
    localparam int COUNT_W = 4;
    localparam logic [COUNT_W-1:0] SURVIVE_COUNT = 4'd2;
    localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;

    // Which sides of the window fall outside the grid.
    typedef struct packed {
        logic first_row;
        logic last_row;
        logic first_col;
        logic last_col;
    } border_t;

endpackage

// ----- hdl/lgs_cell.sv -----
// ----------------------------------------------------------------------------
// lgs_cell
// One column cell of the line stores; holds one bit of each line and shifts.
// ----------------------------------------------------------------------------
module lgs_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         shift_en,
    input  logic                         inject,
    input  logic [lgs_pkg::LINE_TAPS-1:0] feed_in,
    input  logic [lgs_pkg::LINE_TAPS-1:0] chain_in,
    output logic [lgs_pkg::LINE_TAPS-1:0] chain_out
);

    logic [lgs_pkg::LINE_TAPS-1:0] bits_reg;
    logic [lgs_pkg::LINE_TAPS-1:0] bits_next;

    // The cell at the line's entry point takes fresh data; the others take their neighbor's.
    assign bits_next = inject ? feed_in : chain_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg <= '0;
        end else if (shift_en) begin
            bits_reg <= bits_next;
        end
    end

    assign chain_out = bits_reg;

endmodule

// ----- hdl/lgs_rule.sv -----
// ----------------------------------------------------------------------------
// lgs_rule
// Masks the window at the grid border and applies the B3/S23 rule.
// ----------------------------------------------------------------------------
module lgs_rule (
    input  logic [lgs_pkg::WINDOW_W-1:0] window,
    input  lgs_pkg::border_t             border,
    output logic                         next_alive
);

    logic [lgs_pkg::WINDOW_W-1:0] masked;
    logic [lgs_pkg::COUNT_W-1:0]  count;
    logic                         centre;

    // Cells outside the grid count as dead.
    always_comb begin
        masked = window;
        if (border.first_col) begin
            masked = masked & ~9'b001_001_001;
        end
        if (border.last_col) begin
            masked = masked & ~9'b100_100_100;
        end
        if (border.first_row) begin
            masked = masked & ~9'b000_000_111;
        end
        if (border.last_row) begin
            masked = masked & ~9'b111_000_000;
        end
    end

    // Count the eight neighbors around the center.
    always_comb begin
        count = '0;
        for (int i = 0; i < lgs_pkg::WINDOW_W; i++) begin
            if (i != 4) begin
                count = count + lgs_pkg::COUNT_W'(masked[i]);
            end
        end
    end

    assign centre = masked[4];

    // A live cell survives with two or three neighbors; a dead one is born with three.
    assign next_alive = centre ? ((count == lgs_pkg::SURVIVE_COUNT) ||
                                  (count == lgs_pkg::BIRTH_COUNT))
                               : (count == lgs_pkg::BIRTH_COUNT);

endmodule

// ----- hdl/life_generation_stencil.sv -----
// Latency: the result for cell (r, c) is registered at the transfer of the item
// width+1 raster positions later and is offered on the next cycle.
// Throughput: one item per cycle, set by the line cell chain that shifts once per item.
// A result waiting in the output register does not stall input unless it is not taken.
// Reset: synchronous, active low; both sizes return to 128, position, window,
// line cells and output valid are cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
// life_generation_stencil
// Streaming next-generation engine for the B3/S23 cellular automaton.
// ----------------------------------------------------------------------------
`include "life_generation_stencil_macros.svh"

module life_generation_stencil #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lgs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lgs_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Cell input channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic                              s_alive,
    // Result channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_next_alive,
    output logic [lgs_pkg::POS_FIELD_W-1:0]   m_cell_row,
    output logic [lgs_pkg::POS_FIELD_W-1:0]   m_cell_column,
    output logic                              m_frame_end
);

    localparam int CW     = $clog2(MAX_COLS + 1);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int RH     = $clog2(MAX_ROWS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 2);
    localparam int EXT_CW = (CW > lgs_pkg::CFG_DATA_W) ? CW : lgs_pkg::CFG_DATA_W;
    localparam int EXT_RH = (RH > lgs_pkg::CFG_DATA_W) ? RH : lgs_pkg::CFG_DATA_W;

    logic [lgs_pkg::CFG_DATA_W-1:0] grid_width_reg;
    logic [lgs_pkg::CFG_DATA_W-1:0] grid_height_reg;
    logic [CW-1:0]                  w_eff;
    logic [RH-1:0]                  h_eff;
    logic [COL_W-1:0]               w_last;

    logic [COL_W-1:0]               col_reg;
    logic [COL_W-1:0]               col_next;
    logic [ROW_W-1:0]               row_reg;
    logic [ROW_W-1:0]               row_next;
    logic [CW-1:0]                  col_inc;
    logic [lgs_pkg::WINDOW_W-1:0]   window_reg;
    logic [lgs_pkg::WINDOW_W-1:0]   window_next;

    logic                           in_xfer;
    logic                           cfg_xfer;
    logic                           line_bit;
    logic [lgs_pkg::LINE_TAPS-1:0]  line_in;
    logic [lgs_pkg::LINE_TAPS-1:0]  chain_q    [MAX_COLS];
    logic [lgs_pkg::LINE_TAPS-1:0]  chain_prev [MAX_COLS];
    logic [MAX_COLS-1:0]            inject_sel;
    logic                           tap1;
    logic                           tap2;

    logic                           emit;
    logic [ROW_W-1:0]               orow;
    logic [COL_W-1:0]               ocol;
    lgs_pkg::border_t               border;
    logic                           frame_end_calc;
    logic                           next_alive_calc;

    logic                           m_valid_reg;
    logic                           m_next_alive_reg;
    logic [lgs_pkg::POS_FIELD_W-1:0] m_cell_row_reg;
    logic [lgs_pkg::POS_FIELD_W-1:0] m_cell_column_reg;
    logic                           m_frame_end_reg;

    // Handshakes: the output register frees up when its result is taken.
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_xfer   = s_valid && s_ready;

    // Effective grid size: zero reads as one, oversize is clamped.
    always_comb begin
        if (grid_width_reg == '0) begin
            w_eff = CW'(1);
        end else if (EXT_CW'(grid_width_reg) > EXT_CW'(MAX_COLS)) begin
            w_eff = CW'(MAX_COLS);
        end else begin
            w_eff = CW'(grid_width_reg);
        end
        if (grid_height_reg == '0) begin
            h_eff = RH'(1);
        end else if (EXT_RH'(grid_height_reg) > EXT_RH'(MAX_ROWS)) begin
            h_eff = RH'(MAX_ROWS);
        end else begin
            h_eff = RH'(grid_height_reg);
        end
    end

    assign w_last = COL_W'(w_eff - CW'(1));

    // Flush items feed dead cells into the lines and window.
    assign line_bit = (s_command == lgs_pkg::CMD_FLUSH) ? 1'b0 : s_alive;

    // Line cell chain: data enters at cell MAX_COLS-width and leaves at the last cell,
    // so the tap holds the value from exactly one row earlier.
    assign tap1    = chain_q[MAX_COLS-1][0];
    assign tap2    = chain_q[MAX_COLS-1][1];
    assign line_in = {tap1, line_bit};

    for (genvar k = 0; k < MAX_COLS; k++) begin : g_line
        assign inject_sel[k] = (w_eff == CW'(MAX_COLS - k));
        if (k == 0) begin : g_head
            assign chain_prev[k] = line_in;
        end else begin : g_body
            assign chain_prev[k] = chain_q[k-1];
        end
        lgs_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (in_xfer),
            .inject    (inject_sel[k]),
            .feed_in   (line_in),
            .chain_in  (chain_prev[k]),
            .chain_out (chain_q[k])
        );
    end

    // Window shift: each row drops its oldest column and takes the new tap.
    assign window_next = {line_bit, window_reg[8:7],
                          tap1,     window_reg[5:4],
                          tap2,     window_reg[2:1]};

    // The centre of the window lies one row and one column behind the stream.
    always_comb begin
        emit = 1'b0;
        orow = '0;
        if (col_reg != '0) begin
            emit = (row_reg >= ROW_W'(1));
            if (emit) begin
                orow = row_reg - ROW_W'(1);
            end
            ocol = col_reg - COL_W'(1);
        end else begin
            emit = (row_reg >= ROW_W'(2));
            if (emit) begin
                orow = row_reg - ROW_W'(2);
            end
            ocol = w_last;
        end
        if (orow >= ROW_W'(h_eff)) begin
            emit = 1'b0;
        end
    end

    assign border.first_row = (orow == '0);
    assign border.last_row  = (orow == ROW_W'(h_eff - RH'(1)));
    assign border.first_col = (ocol == '0);
    assign border.last_col  = (ocol == w_last);
    assign frame_end_calc   = border.last_row && border.last_col;

    lgs_rule u_rule (
        .window     (window_next),
        .border     (border),
        .next_alive (next_alive_calc)
    );

    // Raster position of the next item.
    always_comb begin
        col_inc = CW'(col_reg) + CW'(1);
        if (col_inc >= w_eff) begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end else begin
            col_next = COL_W'(col_inc);
            row_next = row_reg;
        end
    end

    // Configuration, stream position, window and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= lgs_pkg::GRID_SIZE_RESET;
            grid_height_reg <= lgs_pkg::GRID_SIZE_RESET;
            col_reg         <= '0;
            row_reg         <= '0;
            window_reg      <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_xfer) begin
                unique case (lgs_pkg::cfg_reg_t'(cfg_index))
                    lgs_pkg::REG_GRID_WIDTH: begin
                        grid_width_reg <= cfg_data;
                    end
                    lgs_pkg::REG_GRID_HEIGHT: begin
                        grid_height_reg <= cfg_data;
                    end
                    default: begin
                        grid_width_reg <= grid_width_reg;
                    end
                endcase
                col_reg    <= '0;
                row_reg    <= '0;
                window_reg <= '0;
            end else if (in_xfer) begin
                if (emit && frame_end_calc) begin
                    col_reg    <= '0;
                    row_reg    <= '0;
                    window_reg <= '0;
                end else begin
                    col_reg    <= col_next;
                    row_reg    <= row_next;
                    window_reg <= window_next;
                end
            end

            if (in_xfer && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload is captured with each produced cell.
    always_ff @(posedge aclk) begin
        if (in_xfer && emit) begin
            m_next_alive_reg  <= next_alive_calc;
            m_cell_row_reg    <= lgs_pkg::POS_FIELD_W'(orow);
            m_cell_column_reg <= lgs_pkg::POS_FIELD_W'(ocol);
            m_frame_end_reg   <= frame_end_calc;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_next_alive  = m_next_alive_reg;
    assign m_cell_row    = m_cell_row_reg;
    assign m_cell_column = m_cell_column_reg;
    assign m_frame_end   = m_frame_end_reg;

    // A held result must block the input side.
    `LGS_ASSERT_SAME(a_hold_blocks_input, m_valid_reg && !m_ready, !s_ready, "input taken while result is held")
    // The column counter stays inside the grid width.
    `LGS_ASSERT_SAME(a_col_bound, 1'b1, CW'(col_reg) < w_eff, "column position beyond grid width")
    // The row counter never runs past the flush rows.
    `LGS_ASSERT_SAME(a_row_bound, 1'b1, (ROW_W+1)'(row_reg) <= ((ROW_W+1)'(h_eff) + (ROW_W+1)'(1)), "row position beyond flush rows")
    // The last cell of a frame restarts the stream.
    `LGS_ASSERT_NEXT(a_frame_restart, in_xfer && !cfg_xfer && emit && frame_end_calc, (col_reg == '0) && (row_reg == '0) && (window_reg == '0), "frame did not restart")

endmodule

// ----- dv/tb_life_generation_stencil.sv -----
// ----------------------------------------------------------------------------
// tb_life_generation_stencil
// Self-checking bench for the B3/S23 stencil. Grids are streamed as raster
// frames with random content, dirty frames and noise under random sizes,
// with bursty input and a stalling result sink. Each result is compared
// against a cycle-free model of the line stores and the 3x3 window.
// ----------------------------------------------------------------------------
module tb_life_generation_stencil;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH       = 128;
    localparam int ROW_LIMIT        = 128;
    localparam int RANDOM_ITEMS     = 1360;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int EXTREME_SIZES    = 5;

    // Window masks for cells on the border of the grid.
    localparam bit [lgs_pkg::WINDOW_W-1:0] LEFT_COL   = 9'b001_001_001;
    localparam bit [lgs_pkg::WINDOW_W-1:0] RIGHT_COL  = 9'b100_100_100;
    localparam bit [lgs_pkg::WINDOW_W-1:0] TOP_ROW    = 9'b000_000_111;
    localparam bit [lgs_pkg::WINDOW_W-1:0] BOTTOM_ROW = 9'b111_000_000;

    // Grid sizes at and beyond the limits; zero and oversize values are clamped.
    localparam bit [lgs_pkg::CFG_DATA_W-1:0] EXTREME_COLS [EXTREME_SIZES] =
        '{8'd255, 8'd0, 8'd0, 8'd128, 8'd1};
    localparam bit [lgs_pkg::CFG_DATA_W-1:0] EXTREME_ROWS [EXTREME_SIZES] =
        '{8'd1, 8'd128, 8'd0, 8'd0, 8'd255};

    // A vertical blinker on a 3x3 grid, bit i is raster position i.
    localparam bit [8:0] BLINKER = 9'b010_010_010;

    typedef enum int {FRAME_CLEAN, FRAME_DIRTY, FRAME_NOISE} frame_style_t;
    typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_SPARSE, SINK_TOGGLE} sink_pattern_t;

    typedef struct packed {
        logic                            next_alive;
        logic [lgs_pkg::POS_FIELD_W-1:0] cell_row;
        logic [lgs_pkg::POS_FIELD_W-1:0] cell_column;
        logic                            frame_end;
    } cell_result_t;

    // Predicts the next generation from the accepted cell stream and checks results.
    class life_scoreboard;
        int unsigned                     error_count;
        bit [lgs_pkg::CFG_DATA_W-1:0]    width_reg;
        bit [lgs_pkg::CFG_DATA_W-1:0]    height_reg;
        bit                              line_above [LINE_DEPTH];
        bit                              line_two_above [LINE_DEPTH];
        bit [lgs_pkg::WINDOW_W-1:0]      window;
        bit [lgs_pkg::POS_FIELD_W-1:0]   stream_column;
        bit [7:0]                        stream_row;
        cell_result_t                    next_gen_due [$];

        function new();
            error_count = 0;
            width_reg   = lgs_pkg::GRID_SIZE_RESET;
            height_reg  = lgs_pkg::GRID_SIZE_RESET;
            foreach (line_above[i]) begin
                line_above[i]     = 1'b0;
                line_two_above[i] = 1'b0;
            end
            restart_frame();
        endfunction

        static function int unsigned clamp_size(bit [lgs_pkg::CFG_DATA_W-1:0] value,
                                                int unsigned limit);
            if (value == 0) return 1;
            if (value > limit) return limit;
            return value;
        endfunction

        function void restart_frame();
            window        = '0;
            stream_column = '0;
            stream_row    = '0;
        endfunction

        // A register write also restarts the frame; the line stores keep their data.
        function void note_config(lgs_pkg::cfg_reg_t index,
                                  bit [lgs_pkg::CFG_DATA_W-1:0] value);
            unique case (index)
                lgs_pkg::REG_GRID_WIDTH: begin
                    width_reg = value;
                end
                lgs_pkg::REG_GRID_HEIGHT: begin
                    height_reg = value;
                end
            endcase
            restart_frame();
        endfunction

        // Advance the raster by one item and queue the cell that it completes, if any.
        function void note_cell(logic command, logic alive_in);
            int unsigned                cols, rows, col, row, out_row, out_col, count;
            bit                         fresh, tap1, tap2, centre, emit;
            bit [lgs_pkg::WINDOW_W-1:0] nb;
            cell_result_t               res;
            cols  = clamp_size(width_reg, LINE_DEPTH);
            rows  = clamp_size(height_reg, ROW_LIMIT);
            col   = stream_column;
            row   = stream_row;
            fresh = (command == lgs_pkg::CMD_FLUSH) ? 1'b0 : alive_in;
            tap1  = line_above[col % LINE_DEPTH];
            tap2  = line_two_above[col % LINE_DEPTH];
            line_two_above[col % LINE_DEPTH] = tap1;
            line_above[col % LINE_DEPTH]     = fresh;
            window = {fresh, window[8:7], tap1, window[5:4], tap2, window[2:1]};

            // The window centre lags the stream by one row and one column.
            if (col >= 1) begin
                emit    = (row >= 1);
                out_row = emit ? row - 1 : 0;
                out_col = col - 1;
            end else begin
                emit    = (row >= 2);
                out_row = emit ? row - 2 : 0;
                out_col = cols - 1;
            end
            if (out_row >= rows) emit = 1'b0;

            col++;
            if (col >= cols) begin
                col = 0;
                row++;
            end
            stream_column = col[lgs_pkg::POS_FIELD_W-1:0];
            stream_row    = row[7:0];
            if (!emit) return;

            // Neighbors outside the grid count as dead.
            nb = window;
            if (out_col == 0) nb &= ~LEFT_COL;
            if (out_col == cols - 1) nb &= ~RIGHT_COL;
            if (out_row == 0) nb &= ~TOP_ROW;
            if (out_row == rows - 1) nb &= ~BOTTOM_ROW;
            centre = nb[4];
            nb[4]  = 1'b0;
            count  = $countones(nb);

            res.next_alive  = centre ? (count == lgs_pkg::SURVIVE_COUNT ||
                                        count == lgs_pkg::BIRTH_COUNT)
                                     : (count == lgs_pkg::BIRTH_COUNT);
            res.cell_row    = out_row[lgs_pkg::POS_FIELD_W-1:0];
            res.cell_column = out_col[lgs_pkg::POS_FIELD_W-1:0];
            res.frame_end   = (out_row == rows - 1) && (out_col == cols - 1);
            next_gen_due.push_back(res);
            if (res.frame_end) restart_frame();
        endfunction

        function void compare_field(string name, logic [lgs_pkg::POS_FIELD_W-1:0] want,
                                    logic [lgs_pkg::POS_FIELD_W-1:0] got);
            if (got !== want) begin
                error_count++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_cell(cell_result_t got);
            cell_result_t want;
            if (next_gen_due.size() == 0) begin
                error_count++;
                $display("%0t ns: unexpected result, expected none, actual row %0d column %0d",
                         $time, got.cell_row, got.cell_column);
                return;
            end
            want = next_gen_due.pop_front();
            compare_field("next_alive", want.next_alive, got.next_alive);
            compare_field("cell_row", want.cell_row, got.cell_row);
            compare_field("cell_column", want.cell_column, got.cell_column);
            compare_field("frame_end", want.frame_end, got.frame_end);
        endfunction

        function int unsigned pending();
            return next_gen_due.size();
        endfunction
    endclass

    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [lgs_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [lgs_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                            s_valid       = 1'b0;
    logic                            s_ready;
    logic                            s_command     = 1'b0;
    logic                            s_alive       = 1'b0;
    logic                            m_valid;
    logic                            m_ready       = 1'b0;
    logic                            m_next_alive;
    logic [lgs_pkg::POS_FIELD_W-1:0] m_cell_row;
    logic [lgs_pkg::POS_FIELD_W-1:0] m_cell_column;
    logic                            m_frame_end;

    life_scoreboard sb = new();
    int unsigned    items_sent    = 0;
    int unsigned    burst_left    = 0;
    int unsigned    frame_cols    = LINE_DEPTH;
    int unsigned    frame_rows    = ROW_LIMIT;
    bit             hold_request  = 1'b0;

    life_generation_stencil i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_alive       (s_alive),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_alive  (m_next_alive),
        .m_cell_row    (m_cell_row),
        .m_cell_column (m_cell_column),
        .m_frame_end   (m_frame_end)
    );

    always #5 aclk = ~aclk;

    // Every transfer on the three channels is seen here at the edge that makes it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.note_config(lgs_pkg::cfg_reg_t'(cfg_index), cfg_data);
            if (s_valid && s_ready) sb.note_cell(s_command, s_alive);
            if (m_valid && m_ready)
                sb.check_cell('{m_next_alive, m_cell_row, m_cell_column, m_frame_end});
        end
    end

    // Offer one item in bursts of random length with random gaps between them.
    task automatic offer_item(logic command, logic alive);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge aclk);
            burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(300, 100)
                                                     : $urandom_range(30, 1);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_command <= command;
        s_alive   <= alive;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Let every expected result come out, then give the pipeline time to empty.
    task automatic settle_grid();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_grid_reg(lgs_pkg::cfg_reg_t index,
                                  bit [lgs_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Resize the grid while the block is idle; both registers in random order.
    task automatic set_grid(bit [lgs_pkg::CFG_DATA_W-1:0] cols,
                            bit [lgs_pkg::CFG_DATA_W-1:0] rows);
        settle_grid();
        if ($urandom_range(1, 0)) begin
            write_grid_reg(lgs_pkg::REG_GRID_WIDTH, cols);
            write_grid_reg(lgs_pkg::REG_GRID_HEIGHT, rows);
        end else begin
            write_grid_reg(lgs_pkg::REG_GRID_HEIGHT, rows);
            write_grid_reg(lgs_pkg::REG_GRID_WIDTH, cols);
        end
        cfg_valid  <= 1'b0;
        frame_cols  = life_scoreboard::clamp_size(cols, LINE_DEPTH);
        frame_rows  = life_scoreboard::clamp_size(rows, ROW_LIMIT);
    endtask

    // One generation: cells in raster order then width+1 flush items; dirty and noise frames mix in random commands.
    task automatic feed_frame(frame_style_t style);
        int unsigned density, cells, total;
        density = $urandom_range(100, 0);
        cells   = frame_cols * frame_rows;
        case (style)
            FRAME_CLEAN: begin
                repeat (cells)
                    offer_item(lgs_pkg::CMD_CELL, $urandom_range(99, 0) < density);
                repeat (frame_cols + 1)
                    offer_item(lgs_pkg::CMD_FLUSH, 1'($urandom_range(1, 0)));
            end
            FRAME_DIRTY: begin
                // Stray flushes inside the grid read as dead cells; cells in the
                // flush tail only feed masked neighbors.
                repeat (cells) begin
                    if ($urandom_range(9, 0) == 0)
                        offer_item(lgs_pkg::CMD_FLUSH, 1'($urandom_range(1, 0)));
                    else
                        offer_item(lgs_pkg::CMD_CELL, $urandom_range(99, 0) < density);
                end
                repeat (frame_cols + 1)
                    offer_item(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
            end
            default: begin
                total = $urandom_range(cells + frame_cols + 1, 1);
                repeat (total)
                    offer_item(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
            end
        endcase
    endtask

    // Result sink: stall patterns of random length, plus one long hold on request.
    initial begin : result_sink
        int unsigned   seg_left;
        sink_pattern_t pattern;
        seg_left = 0;
        pattern  = SINK_OPEN;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(200, 10);
                pattern  = sink_pattern_t'($urandom_range(3, 0));
            end
            seg_left--;
            case (pattern)
                SINK_OPEN: begin
                    m_ready <= 1'b1;
                end
                SINK_RANDOM: begin
                    m_ready <= 1'($urandom_range(1, 0));
                end
                SINK_SPARSE: begin
                    m_ready <= ($urandom_range(3, 0) == 0);
                end
                default: begin
                    m_ready <= !m_ready;
                end
            endcase
        end
    end

    // Main sequence: reset, directed grids, then random grids and frames.
    initial begin : stimulus
        int unsigned  phase, extreme_idx, random_start, pick;
        frame_style_t style;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Part of a frame at the reset size; the write that follows restarts it.
        repeat (160) offer_item(lgs_pkg::CMD_CELL, 1'($urandom_range(1, 0)));

        // A lone cell on a 1x1 grid dies.
        set_grid(8'd1, 8'd1);
        offer_item(lgs_pkg::CMD_CELL, 1'b1);
        offer_item(lgs_pkg::CMD_FLUSH, 1'b0);
        offer_item(lgs_pkg::CMD_FLUSH, 1'b1);

        // Blinker on a 3x3 grid turns from vertical to horizontal.
        set_grid(8'd3, 8'd3);
        for (int i = 0; i < 9; i++) offer_item(lgs_pkg::CMD_CELL, BLINKER[i]);
        repeat (4) offer_item(lgs_pkg::CMD_FLUSH, 1'b0);

        // 2x2 grid with a flush among the cells and cells in the flush tail.
        set_grid(8'd2, 8'd2);
        offer_item(lgs_pkg::CMD_CELL, 1'b1);
        offer_item(lgs_pkg::CMD_FLUSH, 1'b1);
        offer_item(lgs_pkg::CMD_CELL, 1'b1);
        offer_item(lgs_pkg::CMD_CELL, 1'b1);
        offer_item(lgs_pkg::CMD_CELL, 1'b1);
        offer_item(lgs_pkg::CMD_FLUSH, 1'b0);
        offer_item(lgs_pkg::CMD_CELL, 1'b0);

        // Mostly small grids, with one frame at each extreme size in between.
        random_start = items_sent;
        phase        = 0;
        extreme_idx  = 0;
        while (items_sent - random_start < RANDOM_ITEMS || extreme_idx < EXTREME_SIZES) begin
            if (phase % 2 == 1 && extreme_idx < EXTREME_SIZES) begin
                set_grid(EXTREME_COLS[extreme_idx], EXTREME_ROWS[extreme_idx]);
                // The first extreme grid, at the greatest width, runs against a long sink hold to back up the input.
                if (extreme_idx == 0) hold_request = 1'b1;
                feed_frame(FRAME_CLEAN);
                extreme_idx++;
            end else begin
                set_grid(lgs_pkg::CFG_DATA_W'($urandom_range(10, 1)),
                         lgs_pkg::CFG_DATA_W'($urandom_range(10, 1)));
                repeat ($urandom_range(4, 1)) begin
                    pick  = $urandom_range(9, 0);
                    style = (pick < 6) ? FRAME_CLEAN : (pick < 8) ? FRAME_DIRTY : FRAME_NOISE;
                    feed_frame(style);
                end
            end
            phase++;
        end

        settle_grid();
        if (sb.error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin : watchdog
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/lgs_pkg.sv
hdl/lgs_cell.sv
hdl/lgs_rule.sv
hdl/life_generation_stencil.sv
dv/tb_life_generation_stencil.sv
